@@ design/move_visit_count_table_core_defines.svh @@
// assertion macros for the checker file
`ifndef MOVE_VISIT_COUNT_TABLE_CORE_DEFINES_SVH
`define MOVE_VISIT_COUNT_TABLE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MVCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mvct check failed");

// next-cycle implication, disabled while reset is low
`define MVCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mvct check failed");

`endif

@@ design/mvct_pkg.sv @@
package mvct_pkg;

    // item kinds
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // fixed field widths of the stream items
    localparam int KIND_W     = 2;
    localparam int MOVE_W     = 16;
    localparam int NODE_W     = 32;
    localparam int FIELD_W    = 48;
    localparam int SLOT_W     = 3;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 104;

    // scale limit after reset
    localparam logic [FIELD_W-1:0] SCALE_LIMIT_RESET = 48'd35184372088831;

    // control from the sequencer to every cell of the chain
    typedef struct packed {
        logic shift;
        logic clear;
    } t_chain_ctrl;

    // one finished result
    typedef struct packed {
        logic               found;
        logic               placed;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] slot_count;
        logic [FIELD_W-1:0] total_count;
        logic               scaled;
    } t_result;

endpackage

@@ design/mvct_cell.sv @@
module mvct_cell #(
    parameter int KEY_BITS   = 16,
    parameter int COUNT_BITS = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mvct_pkg::t_chain_ctrl  i_ctrl,
    input  logic [KEY_BITS-1:0]    i_key,
    input  logic [COUNT_BITS-1:0]  i_count,
    output logic [KEY_BITS-1:0]    o_key,
    output logic [COUNT_BITS-1:0]  o_count
);
    import mvct_pkg::*;

    logic [KEY_BITS-1:0]   r_key;
    logic [COUNT_BITS-1:0] r_count;

    // one table entry, emptied by clear, loaded from the neighbor on shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_count <= '0;
        end else if (i_ctrl.clear) begin
            r_key   <= '0;
            r_count <= '0;
        end else if (i_ctrl.shift) begin
            r_key   <= i_key;
            r_count <= i_count;
        end
    end

    assign o_key   = r_key;
    assign o_count = r_count;

endmodule

@@ design/mvct_scan.sv @@
module mvct_scan #(
    parameter int ENTRIES    = 8,
    parameter int COUNT_BITS = 48,
    parameter int KEY_BITS   = 16,
    parameter int IDX_W      = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // new item
    input  logic                          i_start,
    input  logic [mvct_pkg::KIND_W-1:0]   i_kind,
    input  logic [mvct_pkg::MOVE_W-1:0]   i_move_code,
    input  logic [mvct_pkg::NODE_W-1:0]   i_node_count,
    input  logic [COUNT_BITS-1:0]         i_scale_limit,
    output logic                          o_ready,
    // chain head and tail
    input  logic [KEY_BITS-1:0]           i_head_key,
    input  logic [COUNT_BITS-1:0]         i_head_count,
    output logic [KEY_BITS-1:0]           o_tail_key,
    output logic [COUNT_BITS-1:0]         o_tail_count,
    output mvct_pkg::t_chain_ctrl         o_chain,
    // result
    input  logic                          i_res_free,
    output logic                          o_res_valid,
    output mvct_pkg::t_result             o_res
);
    import mvct_pkg::*;

    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_UPDATE,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [KIND_W-1:0]     r_kind;
    logic [KEY_BITS-1:0]   r_key;
    logic [NODE_W-1:0]     r_add;
    logic [IDX_W-1:0]      r_step;
    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_cnt;
    logic                  r_pick_ok;
    logic [IDX_W-1:0]      r_pick_idx;
    logic [COUNT_BITS-1:0] r_min;
    logic [COUNT_BITS-1:0] r_acc;
    logic [COUNT_BITS-1:0] r_total;
    logic                  r_found;
    logic                  r_placed;
    logic                  r_scaled;
    logic [IDX_W-1:0]      r_slot;
    logic [COUNT_BITS-1:0] r_slot_cnt;

    logic [KEY_BITS-1:0]   in_key;
    logic [COUNT_BITS-1:0] add_ext;
    logic [COUNT_BITS:0]   head_sum;
    logic [COUNT_BITS-1:0] head_sat;
    logic                  head_match;
    logic                  pick_cond;
    logic                  slot_sel;
    logic [COUNT_BITS-1:0] w_cnt;
    logic [COUNT_BITS-1:0] pass_cnt;
    logic [COUNT_BITS:0]   acc_sum;
    logic [COUNT_BITS-1:0] acc_next;
    logic                  last_step;

    assign in_key    = KEY_BITS'(i_move_code);
    assign add_ext   = COUNT_BITS'(r_add);
    assign last_step = (r_step == LAST_IDX);

    // saturating add of the new visits to the entry at the head
    assign head_sum   = {1'b0, i_head_count} + (COUNT_BITS + 1)'(r_add);
    assign head_sat   = head_sum[COUNT_BITS] ? COUNT_MAX : head_sum[COUNT_BITS-1:0];
    assign head_match = (i_head_key == r_key);

    // replacement candidate: empty, or below both running minimum and added count
    assign pick_cond = (i_head_key == '0) ||
                       ((i_head_count < add_ext) && (i_head_count < r_min));

    // write-back pass: target slot gets the new count, all entries may be halved
    assign slot_sel = (r_state == S_UPDATE) && (r_step == r_slot) && (r_found || r_placed);
    assign w_cnt    = r_found ? (r_scaled ? (r_hit_cnt >> 1) : r_hit_cnt) : add_ext;
    assign pass_cnt = (r_state == S_UPDATE && r_scaled) ? (i_head_count >> 1) : i_head_count;

    always_comb begin
        o_tail_key   = slot_sel ? r_key : i_head_key;
        o_tail_count = slot_sel ? w_cnt : pass_cnt;
    end

    // saturating running total over the written-back entries
    assign acc_sum  = {1'b0, r_acc} + {1'b0, o_tail_count};
    assign acc_next = acc_sum[COUNT_BITS] ? COUNT_MAX : acc_sum[COUNT_BITS-1:0];

    // chain control
    always_comb begin
        o_chain.shift = (r_state == S_SCAN) || (r_state == S_UPDATE);
        o_chain.clear = i_start && (i_kind == KIND_CLEAR);
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE) && i_res_free;

    always_comb begin
        o_res.found       = r_found;
        o_res.placed      = r_placed;
        o_res.slot        = SLOT_W'(r_slot);
        o_res.slot_count  = FIELD_W'(r_slot_cnt);
        o_res.total_count = FIELD_W'(r_total);
        o_res.scaled      = r_scaled;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_kind     <= i_kind;
                        r_key      <= in_key;
                        r_add      <= i_node_count;
                        r_step     <= '0;
                        r_hit      <= 1'b0;
                        r_pick_ok  <= 1'b0;
                        r_min      <= COUNT_MAX;
                        r_found    <= 1'b0;
                        r_placed   <= 1'b0;
                        r_scaled   <= 1'b0;
                        r_slot     <= '0;
                        r_slot_cnt <= '0;
                        case (i_kind)
                            KIND_ADD, KIND_LOOKUP: begin
                                r_state <= (in_key != '0) ? S_SCAN : S_DONE;
                            end
                            KIND_CLEAR: begin
                                r_total <= '0;
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (!r_hit && head_match) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_step;
                        r_hit_cnt <= (r_kind == KIND_ADD) ? head_sat : i_head_count;
                    end
                    if (pick_cond) begin
                        r_pick_ok  <= 1'b1;
                        r_pick_idx <= r_step;
                        r_min      <= i_head_count;
                    end
                    r_step <= last_step ? '0 : r_step + 1'b1;
                    if (last_step) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_found <= r_hit;
                    r_acc   <= '0;
                    r_step  <= '0;
                    if (r_kind == KIND_LOOKUP) begin
                        r_slot     <= r_hit ? r_hit_idx : '0;
                        r_slot_cnt <= r_hit ? r_hit_cnt : '0;
                        r_state    <= S_DONE;
                    end else begin
                        r_placed <= !r_hit && r_pick_ok;
                        r_scaled <= r_hit && (r_hit_cnt >= i_scale_limit);
                        r_slot   <= r_hit ? r_hit_idx : (r_pick_ok ? r_pick_idx : '0);
                        r_state  <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_acc <= acc_next;
                    if (slot_sel) begin
                        r_slot_cnt <= w_cnt;
                    end
                    r_step <= last_step ? '0 : r_step + 1'b1;
                    if (last_step) begin
                        r_total <= acc_next;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/move_visit_count_table_core.sv @@
// Visit count table of ENTRIES move keys with saturating counts and a running total,
// replacing the least used entry on a miss if it is empty or below the added count.
// The entries sit in a ring of cells that rotates one place per cycle during a pass
// past a single compare unit at its head: an add with a nonzero key runs two full
// rotations (search, then write-back with optional halving and total recompute), a
// lookup one rotation, and a clear, a zero key or an unused kind none. One item is
// in work at a time; the result register lets the next item be accepted while a
// result still waits. No clearing pass is needed after reset.
module move_visit_count_table_core #(
    parameter int ENTRIES    = 8,
    parameter int COUNT_BITS = 48,
    parameter int KEY_BITS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration: scale_limit
    input  logic                                i_cfg_we,
    input  logic [mvct_pkg::FIELD_W-1:0]        i_cfg_wdata,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [15:0] move_code, [47:16] node_count
    input  logic [mvct_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // [1:0] kind
    input  logic [mvct_pkg::KIND_W-1:0]         i_s_axis_tuser,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] found, [1] placed, [4:2] slot, [52:5] slot_count,
    // [100:53] total_count, [101] scaled, [103:102] zero
    output logic [mvct_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);
    import mvct_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [COUNT_BITS-1:0] r_scale_limit;
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic                  start;
    logic                  scan_ready;
    logic                  res_free;
    logic                  res_valid;
    t_result               res;
    t_chain_ctrl           chain;
    logic [KEY_BITS-1:0]   tail_key;
    logic [COUNT_BITS-1:0] tail_count;
    logic [KEY_BITS-1:0]   w_key   [ENTRIES];
    logic [COUNT_BITS-1:0] w_count [ENTRIES];

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_limit <= COUNT_BITS'(SCALE_LIMIT_RESET);
        end else if (i_cfg_we) begin
            r_scale_limit <= COUNT_BITS'(i_cfg_wdata);
        end
    end

    assign o_s_axis_tready = scan_ready;
    assign start           = i_s_axis_tvalid && scan_ready;
    assign res_free        = !r_m_valid || i_m_axis_tready;

    // ring of cells, cell 0 is the head, the last cell takes the tail
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        logic [KEY_BITS-1:0]   nb_key;
        logic [COUNT_BITS-1:0] nb_count;

        if (k == ENTRIES - 1) begin : g_tail
            assign nb_key   = tail_key;
            assign nb_count = tail_count;
        end else begin : g_link
            assign nb_key   = w_key[k+1];
            assign nb_count = w_count[k+1];
        end

        mvct_cell #(
            .KEY_BITS   (KEY_BITS),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (chain),
            .i_key   (nb_key),
            .i_count (nb_count),
            .o_key   (w_key[k]),
            .o_count (w_count[k])
        );
    end

    // compare and write-back unit at the head of the ring
    mvct_scan #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS),
        .KEY_BITS   (KEY_BITS),
        .IDX_W      (IDX_W)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_kind        (i_s_axis_tuser),
        .i_move_code   (i_s_axis_tdata[MOVE_W-1:0]),
        .i_node_count  (i_s_axis_tdata[MOVE_W +: NODE_W]),
        .i_scale_limit (r_scale_limit),
        .o_ready       (scan_ready),
        .i_head_key    (w_key[0]),
        .i_head_count  (w_count[0]),
        .o_tail_key    (tail_key),
        .o_tail_count  (tail_count),
        .o_chain       (chain),
        .i_res_free    (res_free),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // output register, one transaction deep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_m_data <= {2'b00, res.scaled, res.total_count, res.slot_count,
                         res.slot, res.placed, res.found};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

@@ design/mvct_checker.sv @@
`include "move_visit_count_table_core_defines.svh"

module mvct_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             i_s_axis_tready,
    input logic                             i_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [mvct_pkg::OUT_DATA_W-1:0]  i_m_axis_tdata
);
    localparam int FOUND_B  = 0;
    localparam int PLACED_B = 1;
    localparam int SCALED_B = 101;

    // a stalled result holds its data
    `MVCT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready, i_m_axis_tvalid && $stable(i_m_axis_tdata))

    // a key is never both matched and placed
    `MVCT_ASSERT_NOW(a_found_or_placed, i_clk, i_rst_n, i_m_axis_tvalid, !(i_m_axis_tdata[FOUND_B] && i_m_axis_tdata[PLACED_B]))

    // no slot and no slot count without a match or a placement
    `MVCT_ASSERT_NOW(a_miss_no_slot, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tdata[FOUND_B] && !i_m_axis_tdata[PLACED_B], i_m_axis_tdata[52:2] == '0)

    // halving happens only on a matched add
    `MVCT_ASSERT_NOW(a_scaled_on_hit, i_clk, i_rst_n, i_m_axis_tvalid && i_m_axis_tdata[SCALED_B], i_m_axis_tdata[FOUND_B])

    // one item in work at a time
    `MVCT_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_s_axis_tvalid && i_s_axis_tready, !i_s_axis_tready)

endmodule

bind move_visit_count_table_core mvct_checker u_mvct_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);

@@ tb/move_visit_count_table_core_test.sv @@
module move_visit_count_table_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mvct_pkg::*;

    localparam int ENTRY_COUNT = 8;
    localparam int RUN_LIMIT = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS = 250;
    localparam int PHASES = 7;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [FIELD_W-1:0] COUNT_MAX = 48'hFFFF_FFFF_FFFF;

    // expected behavior of the table: keys, counts, total and the halving limit
    class visit_table_tracker;
        logic [MOVE_W-1:0]  keys [ENTRY_COUNT];
        logic [FIELD_W-1:0] counts [ENTRY_COUNT];
        logic [FIELD_W-1:0] total;
        logic [FIELD_W-1:0] scale_limit;
        t_result            pending_results [$];
        int                 mismatches;

        function new();
            foreach (keys[i]) begin
                keys[i]   = '0;
                counts[i] = '0;
            end
            total       = '0;
            scale_limit = SCALE_LIMIT_RESET;
            mismatches  = 0;
        endfunction

        // add that sticks at the largest count
        function logic [FIELD_W-1:0] sat_add(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
            logic [63:0] sum;
            sum = {16'b0, a} + {16'b0, b};
            return (sum > {16'b0, COUNT_MAX}) ? COUNT_MAX : sum[FIELD_W-1:0];
        endfunction

        function int locate(logic [MOVE_W-1:0] move);
            for (int i = 0; i < ENTRY_COUNT; i++) begin
                if (keys[i] == move) return i;
            end
            return -1;
        endfunction

        // work out the result of one accepted transaction and queue it
        function void note_item(logic [KIND_W-1:0] kind, logic [MOVE_W-1:0] move,
                                logic [NODE_W-1:0] node);
            t_result     r;
            int          hit;
            int          pick;
            logic [63:0] least;
            r = '0;
            if (kind == KIND_ADD && move != 0) begin
                hit = locate(move);
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.slot = hit[SLOT_W-1:0];
                    counts[hit] = sat_add(counts[hit], {16'b0, node});
                    if (counts[hit] >= scale_limit) begin
                        foreach (counts[i]) counts[i] = counts[i] >> 1;
                        r.scaled = 1'b1;
                    end
                    r.slot_count = counts[hit];
                end else begin
                    // the last empty or least used slot met on the scan is replaced
                    least = '1;
                    pick = -1;
                    for (int i = 0; i < ENTRY_COUNT; i++) begin
                        if (keys[i] == 0 ||
                            ({16'b0, counts[i]} < least && counts[i] < {16'b0, node})) begin
                            least = {16'b0, counts[i]};
                            pick = i;
                        end
                    end
                    if (pick >= 0) begin
                        r.placed = 1'b1;
                        r.slot = pick[SLOT_W-1:0];
                        keys[pick] = move;
                        counts[pick] = {16'b0, node};
                        r.slot_count = counts[pick];
                    end
                end
                total = '0;
                foreach (counts[i]) total = sat_add(total, counts[i]);
            end else if (kind == KIND_LOOKUP && move != 0) begin
                hit = locate(move);
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.slot = hit[SLOT_W-1:0];
                    r.slot_count = counts[hit];
                end
            end else if (kind == KIND_CLEAR) begin
                foreach (keys[i]) begin
                    keys[i]   = '0;
                    counts[i] = '0;
                end
                total = '0;
            end
            r.total_count = total;
            pending_results.insert(pending_results.size(), r);
        endfunction

        task report_mismatch(string field, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
            mismatches++;
            $display("mismatch in %s: expected 0x%0h, got 0x%0h", field, want, got);
        endtask

        // compare one result transaction with the oldest expectation
        task check_result(logic [OUT_DATA_W-1:0] data);
            t_result want;
            if (pending_results.size() == 0) begin
                report_mismatch("result with none expected", '0, data[FIELD_W-1:0]);
            end else begin
                want = pending_results.pop_front();
                if (data[0] !== want.found)
                    report_mismatch("found", FIELD_W'(want.found), FIELD_W'(data[0]));
                if (data[1] !== want.placed)
                    report_mismatch("placed", FIELD_W'(want.placed), FIELD_W'(data[1]));
                if (data[4:2] !== want.slot)
                    report_mismatch("slot", FIELD_W'(want.slot), FIELD_W'(data[4:2]));
                if (data[52:5] !== want.slot_count)
                    report_mismatch("slot_count", want.slot_count, data[52:5]);
                if (data[100:53] !== want.total_count)
                    report_mismatch("total_count", want.total_count, data[100:53]);
                if (data[101] !== want.scaled)
                    report_mismatch("scaled", FIELD_W'(want.scaled), FIELD_W'(data[101]));
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [FIELD_W-1:0]    cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic [IN_DATA_W-1:0]  in_data;
    logic [KIND_W-1:0]     in_user;
    logic                  out_valid;
    logic                  out_ready;
    logic [OUT_DATA_W-1:0] out_data;

    visit_table_tracker    tracker;
    logic [MOVE_W-1:0]     key_pool [12];
    bit                    quiet = 1'b0;
    bit                    hold_off_request = 1'b0;
    int                    idle_pct = 20;
    int                    stall_pct = 10;
    int                    cycles = 0;

    move_visit_count_table_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_user),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data)
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial begin
        while (cycles < RUN_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("move_visit_count_table_core test failed");
        $finish;
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) tracker.check_result(out_data);
    end

    // result receiver: random stalls, one long hold-off on request
    initial begin
        int hold_cycles;
        int ready_cycles;
        ready_cycles = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                out_ready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < HOLD_OFF_CYCLES) begin
                    @(posedge clk);
                    hold_cycles++;
                end
                out_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
            ready_cycles++;
            if (ready_cycles % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
        end
    end

    // offer one transaction and wait until it is taken
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [MOVE_W-1:0] move,
                             input logic [NODE_W-1:0] node);
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_user  <= kind;
        in_data  <= {node, move};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_item(kind, move, node);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_scale_limit(input logic [FIELD_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.scale_limit = value;
    endtask

    function automatic logic [NODE_W-1:0] pick_visits();
        case ($urandom_range(0, 3))
            0, 1: return $urandom_range(0, 31);
            2: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // mostly adds and lookups on a small key set so the table fills and replaces
    task automatic send_random_item();
        int sel;
        logic [MOVE_W-1:0] pool_key;
        sel = $urandom_range(0, 99);
        pool_key = key_pool[$urandom_range(0, 11)];
        if (sel < 60)
            send_item(KIND_ADD, pool_key, pick_visits());
        else if (sel < 85)
            send_item(KIND_LOOKUP, pool_key, $urandom);
        else if (sel < 86)
            send_item(KIND_CLEAR, MOVE_W'($urandom), $urandom);
        else if (sel < 90)
            send_item(KIND_ADD, MOVE_W'($urandom), pick_visits());
        else if (sel < 94)
            send_item(KIND_LOOKUP, MOVE_W'($urandom), $urandom);
        else if (sel < 96)
            send_item($urandom_range(0, 1) ? KIND_ADD : KIND_LOOKUP, '0, $urandom);
        else if (sel < 98)
            send_item(KIND_UNUSED, MOVE_W'($urandom), $urandom);
        else
            send_item(KIND_ADD, pool_key, '0);
    endtask

    // stimulus
    initial begin
        logic [FIELD_W-1:0] limit;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        in_user   <= '0;
        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, zero keys and the unused kind
        send_item(KIND_LOOKUP, 16'd5, 32'd0);
        send_item(KIND_ADD, 16'd0, 32'd7);
        send_item(KIND_LOOKUP, 16'd0, 32'd0);
        send_item(KIND_UNUSED, 16'd1, 32'hFFFF_FFFF);
        // fill every slot
        send_item(KIND_ADD, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(KIND_ADD, 16'h0001, 32'd0);
        send_item(KIND_ADD, 16'h8000, 32'd3);
        send_item(KIND_ADD, 16'h5555, 32'd4);
        send_item(KIND_ADD, 16'hAAAA, 32'd5);
        send_item(KIND_ADD, 16'h0100, 32'd6);
        send_item(KIND_ADD, 16'h0002, 32'd7);
        send_item(KIND_ADD, 16'h7FFF, 32'd8);
        // full table: no slot to replace, then a replacement of the least used
        send_item(KIND_ADD, 16'h0009, 32'd0);
        send_item(KIND_ADD, 16'h0009, 32'd2);
        send_item(KIND_ADD, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(KIND_LOOKUP, 16'hFFFF, 32'd0);
        send_item(KIND_LOOKUP, 16'h1234, 32'd0);
        send_item(KIND_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(KIND_LOOKUP, 16'hFFFF, 32'd0);
        drain();

        // zero limit halves on every matching add
        write_scale_limit('0);
        send_item(KIND_ADD, 16'h0003, 32'd5);
        send_item(KIND_ADD, 16'h0003, 32'd1);
        drain();
        write_scale_limit(48'd1);
        send_item(KIND_ADD, 16'h0003, 32'd0);
        drain();
        write_scale_limit(COUNT_MAX);
        send_item(KIND_ADD, 16'h0003, 32'hFFFF_FFFF);
        send_item(KIND_LOOKUP, 16'h0003, 32'd0);
        drain();

        // random phases, each under its own limit; the last one without idling
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: limit = FIELD_W'($urandom_range(1, 64));
                1: limit = FIELD_W'($urandom_range(64, 100000));
                2: limit = {16'($urandom_range(0, 65535)), $urandom};
                3: limit = COUNT_MAX;
                4: limit = FIELD_W'($urandom_range(1, 16));
                5: limit = SCALE_LIMIT_RESET;
                default: limit = FIELD_W'($urandom_range(32, 5000));
            endcase
            write_scale_limit(limit);
            foreach (key_pool[i]) key_pool[i] = MOVE_W'($urandom_range(1, 65535));
            if (phase == 1) hold_off_request = 1'b1;
            if (phase == PHASES - 1) quiet = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) begin
                    case ($urandom_range(0, 2))
                        0: idle_pct = 0;
                        1: idle_pct = 15;
                        default: idle_pct = 40;
                    endcase
                end
                send_random_item();
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("move_visit_count_table_core test passed");
        else
            $display("move_visit_count_table_core test failed");
        $finish;
    end

endmodule

@@ move_visit_count_table_core.f @@
+incdir+design
design/mvct_pkg.sv
design/mvct_cell.sv
design/mvct_scan.sv
design/move_visit_count_table_core.sv
design/mvct_checker.sv
tb/move_visit_count_table_core_test.sv
